FILE: design/dipc_pkg.sv
// shared types and constants for the debounced inputs and pulse counters block
`default_nettype none

package dipc_pkg;

    localparam int BUTTON_CH = 8;
    localparam int SENSOR_CH = 8;
    localparam int METER_CH = 4;
    localparam int METER_IDX_W = 2;
    localparam int COUNT_W = 32;
    localparam int MASK_W = 8;

    localparam int DEF_NUM_BUTTONS = 8;
    localparam int DEF_NUM_SENSORS = 8;
    localparam int DEF_NUM_METERS = 4;
    localparam int DEF_HISTORY_LEN = 8;

    localparam logic [MASK_W-1:0] BUTTON_INVERT_RESET = 8'hFF;
    localparam logic [MASK_W-1:0] SENSOR_INVERT_RESET = 8'h00;

    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_SNAPSHOT = 2'd1,
        CMD_COMMIT   = 2'd2,
        CMD_NONE     = 2'd3
    } cmd_t;

    typedef enum logic {
        REG_BUTTON_INVERT = 1'b0,
        REG_SENSOR_INVERT = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]             command;
        logic [BUTTON_CH-1:0]   raw_buttons;
        logic [SENSOR_CH-1:0]   raw_sensors;
        logic [METER_CH-1:0]    raw_meters;
        logic [METER_IDX_W-1:0] meter_index;
    } sample_word_t;

    typedef struct packed {
        logic [BUTTON_CH-1:0] buttons_pressed;
        logic [SENSOR_CH-1:0] sensors_pressed;
        logic [COUNT_W-1:0]   meter_count;
    } result_word_t;

    typedef struct packed {
        logic tick;
        logic snapshot;
        logic commit;
    } meter_ctl_t;

endpackage

`default_nettype wire

FILE: design/debounced_inputs_with_pulse_counters.sv
// top level: config registers, debounce and meter lanes, merge and result register
//
// usage
//   sample channel: sample_valid/sample_stall carry one sample_word_t per word;
//     a word is taken at a clock edge with sample_valid high and sample_stall low
//   command tick shifts the pin levels into every channel history, snapshot
//     freezes and returns the addressed meter count, commit subtracts the frozen
//     value from that meter count
//   result channel: result_valid/result_stall carry one result_word_t per word
//   the result is registered and shows up the cycle after its sample word is taken
//   throughput is one word per cycle unless stalled; all lanes update in parallel
//     and the merge is one level of selection in front of the result register
//   when the receiver stalls, the result register holds and sample_stall is
//     raised only while that register is full and stalled
//   the apb port writes the invert masks at byte addresses 0 and 4
//   reset clears every history, arming bit, count and frozen value and loads
//     the invert masks with their reset values; no clearing pass is needed
`default_nettype none

module debounced_inputs_with_pulse_counters
    import dipc_pkg::*;
#(
    parameter int NUM_BUTTONS = DEF_NUM_BUTTONS,
    parameter int NUM_SENSORS = DEF_NUM_SENSORS,
    parameter int NUM_METERS  = DEF_NUM_METERS,
    parameter int HISTORY_LEN = DEF_HISTORY_LEN
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,

    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,

    input  wire logic         sample_valid,
    output logic              sample_stall,
    input  wire sample_word_t sample_word,

    output logic              result_valid,
    input  wire logic         result_stall,
    output result_word_t      result_word
);

    logic [MASK_W-1:0] button_invert_reg;
    logic [MASK_W-1:0] sensor_invert_reg;
    logic              cfg_write;
    reg_idx_t          cfg_idx;

    logic              sample_accept;
    logic              do_tick;
    logic              do_snapshot;
    logic              do_commit;

    logic [BUTTON_CH-1:0] button_level;
    logic [SENSOR_CH-1:0] sensor_level;
    logic [BUTTON_CH-1:0] buttons_pressed;
    logic [SENSOR_CH-1:0] sensors_pressed;
    logic [COUNT_W-1:0]   meter_ticks [NUM_METERS];
    logic [COUNT_W-1:0]   count_sel;

    logic                 result_valid_reg;
    logic                 result_valid_next;
    result_word_t         result_word_reg;
    result_word_t         result_word_next;

    // config port
    assign pready = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            button_invert_reg <= BUTTON_INVERT_RESET;
            sensor_invert_reg <= SENSOR_INVERT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_BUTTON_INVERT: button_invert_reg <= pwdata[MASK_W-1:0];
                REG_SENSOR_INVERT: sensor_invert_reg <= pwdata[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_BUTTON_INVERT: prdata = {{(32-MASK_W){1'b0}}, button_invert_reg};
            REG_SENSOR_INVERT: prdata = {{(32-MASK_W){1'b0}}, sensor_invert_reg};
            default:           prdata = '0;
        endcase
    end

    // handshake and command decode
    assign sample_stall = result_valid_reg && result_stall;
    assign sample_accept = sample_valid && !sample_stall;

    always_comb
    begin
        do_tick = 1'b0;
        do_snapshot = 1'b0;
        do_commit = 1'b0;
        unique case (cmd_t'(sample_word.command))
            CMD_TICK:     do_tick = sample_accept;
            CMD_SNAPSHOT: do_snapshot = sample_accept;
            CMD_COMMIT:   do_commit = sample_accept;
            default: ;
        endcase
    end

    assign button_level = sample_word.raw_buttons ^ button_invert_reg;
    assign sensor_level = sample_word.raw_sensors ^ sensor_invert_reg;

    // lanes
    for (genvar c = 0; c < BUTTON_CH; c++)
    begin : g_button
        if (c < NUM_BUTTONS)
        begin : g_lane
            dipc_debounce_lane #(
                .HISTORY_LEN(HISTORY_LEN)
            ) u_lane (
                .clk    (clk),
                .rst_n  (rst_n),
                .shift  (do_tick),
                .level  (button_level[c]),
                .pressed(buttons_pressed[c])
            );
        end
        else
        begin : g_unused
            assign buttons_pressed[c] = 1'b0;
        end
    end

    for (genvar c = 0; c < SENSOR_CH; c++)
    begin : g_sensor
        if (c < NUM_SENSORS)
        begin : g_lane
            dipc_debounce_lane #(
                .HISTORY_LEN(HISTORY_LEN)
            ) u_lane (
                .clk    (clk),
                .rst_n  (rst_n),
                .shift  (do_tick),
                .level  (sensor_level[c]),
                .pressed(sensors_pressed[c])
            );
        end
        else
        begin : g_unused
            assign sensors_pressed[c] = 1'b0;
        end
    end

    for (genvar c = 0; c < NUM_METERS; c++)
    begin : g_meter
        meter_ctl_t ctl;
        logic       hit;

        assign hit = (sample_word.meter_index == METER_IDX_W'(c));
        assign ctl.tick = do_tick;
        assign ctl.snapshot = do_snapshot && hit;
        assign ctl.commit = do_commit && hit;

        dipc_meter_lane #(
            .HISTORY_LEN(HISTORY_LEN)
        ) u_lane (
            .clk  (clk),
            .rst_n(rst_n),
            .ctl  (ctl),
            .level(sample_word.raw_meters[c]),
            .ticks(meter_ticks[c])
        );
    end

    // merge
    always_comb
    begin
        count_sel = '0;
        for (int c = 0; c < NUM_METERS; c++)
        begin
            if (sample_word.meter_index == METER_IDX_W'(c))
            begin
                count_sel = meter_ticks[c];
            end
        end
    end

    always_comb
    begin
        result_word_next.buttons_pressed = buttons_pressed;
        result_word_next.sensors_pressed = sensors_pressed;
        result_word_next.meter_count = do_snapshot ? count_sel : '0;
        result_valid_next = sample_accept || (result_valid_reg && result_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_accept)
        begin
            result_word_reg <= result_word_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_word = result_word_reg;

`ifndef ASSERT_OFF
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        sample_accept |=> result_valid)
        else $error("accepted word produced no result");
    a_count_only_on_snapshot: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_accept && !do_snapshot) |=> (result_word.meter_count == '0))
        else $error("meter count reported outside a snapshot");
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (result_valid && result_stall))
        else $error("sample side stalled with the result register free");
    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({do_tick, do_snapshot, do_commit}))
        else $error("more than one command decoded");
`endif

endmodule

`default_nettype wire

FILE: design/dipc_debounce_lane.sv
// one debounce channel: sample history and all-high detect
`default_nettype none

module dipc_debounce_lane
    import dipc_pkg::*;
#(
    parameter int HISTORY_LEN = DEF_HISTORY_LEN
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic shift,
    input  wire logic level,
    output logic      pressed
);

    logic [HISTORY_LEN-1:0] hist_reg;
    logic [HISTORY_LEN-1:0] hist_next;

    always_comb
    begin
        hist_next = hist_reg;
        if (shift)
        begin
            hist_next = {hist_reg[HISTORY_LEN-2:0], level};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '0;
        end
        else
        begin
            hist_reg <= hist_next;
        end
    end

    // pressed as seen after this word's update
    assign pressed = &hist_next;

endmodule

`default_nettype wire

FILE: design/dipc_meter_lane.sv
// one pulse meter channel: history, arming, count and frozen snapshot
`default_nettype none

module dipc_meter_lane
    import dipc_pkg::*;
#(
    parameter int HISTORY_LEN = DEF_HISTORY_LEN
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire meter_ctl_t         ctl,
    input  wire logic               level,
    output logic [COUNT_W-1:0]      ticks
);

    logic [HISTORY_LEN-1:0] hist_reg;
    logic [HISTORY_LEN-1:0] hist_next;
    logic                   armed_reg;
    logic                   armed_next;
    logic [COUNT_W-1:0]     ticks_reg;
    logic [COUNT_W-1:0]     ticks_next;
    logic [COUNT_W-1:0]     frozen_reg;
    logic [COUNT_W-1:0]     frozen_next;

    always_comb
    begin
        hist_next = hist_reg;
        armed_next = armed_reg;
        ticks_next = ticks_reg;
        frozen_next = frozen_reg;
        if (ctl.tick)
        begin
            hist_next = {hist_reg[HISTORY_LEN-2:0], level};
            if (&hist_next)
            begin
                if (armed_reg)
                begin
                    armed_next = 1'b0;
                    ticks_next = ticks_reg + COUNT_W'(1);
                end
            end
            else
            begin
                armed_next = 1'b1;
            end
        end
        if (ctl.snapshot)
        begin
            frozen_next = ticks_reg;
        end
        if (ctl.commit)
        begin
            ticks_next = ticks_reg - frozen_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '0;
            armed_reg <= 1'b0;
            ticks_reg <= '0;
            frozen_reg <= '0;
        end
        else
        begin
            hist_reg <= hist_next;
            armed_reg <= armed_next;
            ticks_reg <= ticks_next;
            frozen_reg <= frozen_next;
        end
    end

    assign ticks = ticks_reg;

`ifndef ASSERT_OFF
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.tick && !ctl.commit) |=>
            (ticks_reg == $past(ticks_reg) || ticks_reg == $past(ticks_reg) + COUNT_W'(1)))
        else $error("meter count moved by more than one on a tick");
    a_count_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        (ticks_reg == $past(ticks_reg) + COUNT_W'(1) && $past(ctl.tick)) |-> !armed_reg)
        else $error("meter still armed after counting");
    a_arm_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.tick && !(&hist_next)) |=> armed_reg)
        else $error("meter not armed after a non-full history");
`endif

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// testbench for the debounced inputs and pulse counters block: directed table, then random words
`default_nettype none

module tb_top;
    import dipc_pkg::*;

    localparam int HIST = DEF_HISTORY_LEN;
    localparam int PHASES = 6;
    localparam int WORDS_PER_PHASE = 340;
    localparam int LONG_HOLD = 60;
    localparam int IDLE_LIMIT = 1000;
    localparam int DRILL_ROWS = 16;

    typedef struct packed {
        cmd_t         cmd;
        logic [7:0]   btn;
        logic [7:0]   sns;
        logic [3:0]   mtr;
        logic [1:0]   idx;
        logic [3:0]   reps;
        logic         typed;
        result_word_t want;
    } drill_row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         sample_valid = 1'b0;
    logic         sample_stall;
    sample_word_t sample_word = '0;
    logic         result_valid;
    logic         result_stall = 1'b0;
    result_word_t result_word;

    // debounce and meter state mirrored on the bench side
    logic [HIST-1:0] btn_hist [BUTTON_CH];
    logic [HIST-1:0] sns_hist [SENSOR_CH];
    logic [HIST-1:0] mtr_hist [METER_CH];
    logic            mtr_armed [METER_CH];
    logic [31:0]     mtr_count [METER_CH];
    logic [31:0]     mtr_frozen [METER_CH];
    logic [7:0]      btn_mask = BUTTON_INVERT_RESET;
    logic [7:0]      sns_mask = SENSOR_INVERT_RESET;

    result_word_t    pending_results [$];
    drill_row_t      drill_tab [DRILL_ROWS];

    logic            word_typed = 1'b0;
    result_word_t    word_typed_result = '0;
    int              errors = 0;
    int              burst_left = 0;
    int              gap_max = 0;
    int              hold_req = 0;
    int              hold_seen = 0;
    int              hold_left = 0;
    int              seg_left = 0;
    int              stall_pct = 0;
    int              idle_cycles = 0;

    debounced_inputs_with_pulse_counters uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_word  (sample_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_word  (result_word)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic result_word_t sample_and_count(input sample_word_t w);
        result_word_t r;
        logic [7:0]   btn_lvl;
        logic [7:0]   sns_lvl;
        int           m;
        r = '0;
        btn_lvl = w.raw_buttons ^ btn_mask;
        sns_lvl = w.raw_sensors ^ sns_mask;
        m = int'(w.meter_index);
        case (cmd_t'(w.command))
            CMD_TICK:
            begin
                for (int c = 0; c < DEF_NUM_BUTTONS; c++)
                    btn_hist[c] = {btn_hist[c][HIST-2:0], btn_lvl[c]};
                for (int c = 0; c < DEF_NUM_SENSORS; c++)
                    sns_hist[c] = {sns_hist[c][HIST-2:0], sns_lvl[c]};
                for (int c = 0; c < DEF_NUM_METERS; c++)
                begin
                    mtr_hist[c] = {mtr_hist[c][HIST-2:0], w.raw_meters[c]};
                    if (&mtr_hist[c])
                    begin
                        if (mtr_armed[c])
                        begin
                            mtr_armed[c] = 1'b0;
                            mtr_count[c] = mtr_count[c] + 32'd1;
                        end
                    end
                    else
                        mtr_armed[c] = 1'b1;
                end
            end
            CMD_SNAPSHOT:
            begin
                if (m < DEF_NUM_METERS)
                begin
                    mtr_frozen[m] = mtr_count[m];
                    r.meter_count = mtr_count[m];
                end
            end
            CMD_COMMIT:
            begin
                if (m < DEF_NUM_METERS)
                    mtr_count[m] = mtr_count[m] - mtr_frozen[m];
            end
            default:
            begin
            end
        endcase
        for (int c = 0; c < DEF_NUM_BUTTONS; c++)
            r.buttons_pressed[c] = &btn_hist[c];
        for (int c = 0; c < DEF_NUM_SENSORS; c++)
            r.sensors_pressed[c] = &sns_hist[c];
        return r;
    endfunction

    function automatic logic [7:0] flip_bits(input int div);
        logic [7:0] f;
        f = '0;
        for (int b = 0; b < 8; b++)
            f[b] = ($urandom_range(0, div - 1) == 0);
        return f;
    endfunction

    task automatic send_word(input sample_word_t w, input logic typed, input result_word_t want);
        int gap;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 9) == 0)
                gap = $urandom_range(0, gap_max * 4);
            else
                gap = $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                sample_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        word_typed = typed;
        word_typed_result = want;
        sample_word <= w;
        sample_valid <= 1'b1;
        do
            @(posedge clk);
        while (sample_stall);
        @(negedge clk);
    endtask

    task automatic drain_results;
        sample_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [7:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {24'($urandom), value};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_BUTTON_INVERT)
            btn_mask = value;
        else
            sns_mask = value;
    endtask

    // sample side: predict every accepted word
    always @(posedge clk)
    begin : sample_monitor
        result_word_t predicted;
        if (rst_n && sample_valid && !sample_stall)
        begin
            predicted = sample_and_count(sample_word);
            if (word_typed)
                pending_results.push_back(word_typed_result);
            else
                pending_results.push_back(predicted);
        end
    end

    always @(posedge clk)
    begin : result_check
        result_word_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with no expectation pending");
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_word.buttons_pressed !== want.buttons_pressed)
                begin
                    $error("buttons_pressed: expected %h, got %h",
                           want.buttons_pressed, result_word.buttons_pressed);
                    errors++;
                end
                if (result_word.sensors_pressed !== want.sensors_pressed)
                begin
                    $error("sensors_pressed: expected %h, got %h",
                           want.sensors_pressed, result_word.sensors_pressed);
                    errors++;
                end
                if (result_word.meter_count !== want.meter_count)
                begin
                    $error("meter_count: expected %h, got %h",
                           want.meter_count, result_word.meter_count);
                    errors++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else if (hold_seen != hold_req)
        begin
            hold_seen <= hold_req;
            hold_left <= LONG_HOLD;
            result_stall <= 1'b1;
        end
        else
        begin
            if (seg_left == 0)
            begin
                seg_left <= $urandom_range(8, 64);
                case ($urandom_range(0, 3))
                    0: stall_pct <= 0;
                    1: stall_pct <= 20;
                    2: stall_pct <= 50;
                    default: stall_pct <= 85;
                endcase
            end
            else
                seg_left <= seg_left - 1;
            result_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_valid && !sample_stall) || (result_valid && !result_stall) ||
                (psel && penable && pwrite && pready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        sample_word_t w;
        logic [7:0]   held_btn;
        logic [7:0]   held_sns;
        logic [3:0]   held_mtr;
        int           sel;
        int           flip_div;

        for (int c = 0; c < BUTTON_CH; c++)
        begin
            btn_hist[c] = '0;
            sns_hist[c] = '0;
        end
        for (int c = 0; c < METER_CH; c++)
        begin
            mtr_hist[c] = '0;
            mtr_armed[c] = 1'b0;
            mtr_count[c] = '0;
            mtr_frozen[c] = '0;
        end

        drill_tab = '{
            '{CMD_SNAPSHOT, 8'h00, 8'h00, 4'h0, 2'd0, 4'd1, 1'b1, '{8'h00, 8'h00, 32'h0}},
            '{CMD_NONE,     8'hFF, 8'hFF, 4'hF, 2'd3, 4'd1, 1'b1, '{8'h00, 8'h00, 32'h0}},
            '{CMD_COMMIT,   8'h00, 8'h00, 4'h0, 2'd3, 4'd1, 1'b1, '{8'h00, 8'h00, 32'h0}},
            '{CMD_TICK,     8'h00, 8'hFF, 4'hF, 2'd0, 4'd7, 1'b0, '0},
            '{CMD_TICK,     8'h00, 8'hFF, 4'hF, 2'd0, 4'd1, 1'b1, '{8'hFF, 8'hFF, 32'h0}},
            '{CMD_SNAPSHOT, 8'h00, 8'h00, 4'h0, 2'd0, 4'd1, 1'b0, '0},
            '{CMD_COMMIT,   8'h00, 8'h00, 4'h0, 2'd0, 4'd1, 1'b0, '0},
            '{CMD_COMMIT,   8'h00, 8'h00, 4'h0, 2'd0, 4'd1, 1'b0, '0},
            '{CMD_SNAPSHOT, 8'hFF, 8'hFF, 4'hF, 2'd0, 4'd1, 1'b0, '0},
            '{CMD_TICK,     8'h01, 8'hFE, 4'h0, 2'd0, 4'd1, 1'b1, '{8'hFE, 8'hFE, 32'h0}},
            '{CMD_TICK,     8'h00, 8'hFF, 4'hF, 2'd2, 4'd8, 1'b0, '0},
            '{CMD_SNAPSHOT, 8'h00, 8'h00, 4'h0, 2'd0, 4'd1, 1'b0, '0},
            '{CMD_SNAPSHOT, 8'h00, 8'h00, 4'h0, 2'd3, 4'd1, 1'b0, '0},
            '{CMD_TICK,     8'h80, 8'h7F, 4'hA, 2'd1, 4'd1, 1'b0, '0},
            '{CMD_SNAPSHOT, 8'h00, 8'h00, 4'h0, 2'd1, 4'd1, 1'b0, '0},
            '{CMD_SNAPSHOT, 8'h00, 8'h00, 4'h0, 2'd2, 4'd1, 1'b0, '0}
        };

        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        gap_max = 3;
        for (int r = 0; r < DRILL_ROWS; r++)
        begin
            for (int k = 0; k < drill_tab[r].reps; k++)
            begin
                w.command = drill_tab[r].cmd;
                w.raw_buttons = drill_tab[r].btn;
                w.raw_sensors = drill_tab[r].sns;
                w.raw_meters = drill_tab[r].mtr;
                w.meter_index = drill_tab[r].idx;
                send_word(w, drill_tab[r].typed && (k == drill_tab[r].reps - 1),
                          drill_tab[r].want);
            end
        end

        held_btn = 8'($urandom);
        held_sns = 8'($urandom);
        held_mtr = 4'($urandom);
        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph > 0)
            begin
                drain_results();
                case (ph)
                    1:
                    begin
                        apb_write(REG_BUTTON_INVERT, 8'h00);
                        apb_write(REG_SENSOR_INVERT, 8'h00);
                    end
                    2:
                    begin
                        apb_write(REG_BUTTON_INVERT, 8'hFF);
                        apb_write(REG_SENSOR_INVERT, 8'hFF);
                    end
                    3:
                    begin
                        apb_write(REG_BUTTON_INVERT, 8'h00);
                        apb_write(REG_SENSOR_INVERT, 8'hFF);
                    end
                    default:
                    begin
                        apb_write(REG_BUTTON_INVERT, 8'($urandom));
                        apb_write(REG_SENSOR_INVERT, 8'($urandom));
                    end
                endcase
            end
            gap_max = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 4 : 12);
            flip_div = $urandom_range(6, 40);
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                if (ph == 2 && n == 150)
                    hold_req++;
                if (n == 250)
                    drain_results();
                w.raw_buttons = 8'($urandom);
                w.raw_sensors = 8'($urandom);
                w.raw_meters = 4'($urandom);
                w.meter_index = 2'($urandom);
                sel = $urandom_range(0, 99);
                if (sel < 78)
                begin
                    held_btn ^= flip_bits(flip_div);
                    held_sns ^= flip_bits(flip_div);
                    held_mtr ^= 4'(flip_bits(flip_div / 2 + 1));
                    w.command = CMD_TICK;
                    w.raw_buttons = held_btn;
                    w.raw_sensors = held_sns;
                    w.raw_meters = held_mtr;
                end
                else if (sel < 88)
                    w.command = CMD_SNAPSHOT;
                else if (sel < 94)
                    w.command = CMD_COMMIT;
                else if (sel < 97)
                    w.command = CMD_TICK;
                else
                    w.command = CMD_NONE;
                send_word(w, 1'b0, '0);
            end
        end

        drain_results();
        repeat (5) @(negedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
design/dipc_pkg.sv
design/dipc_debounce_lane.sv
design/dipc_meter_lane.sv
design/debounced_inputs_with_pulse_counters.sv
bench/tb_top.sv
